// ----- hdl/slrg_pkg.sv -----
// Shared constants, payload types and slot selection for the shuffled Lehmer generator.
package slrg_pkg;

	// table geometry
	localparam int TBL_DEPTH = 32;
	localparam int WARMUP    = 8;
	localparam int IDX_W     = $clog2(TBL_DEPTH);
	localparam int STEP_W    = $clog2(TBL_DEPTH + WARMUP);
	localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(TBL_DEPTH + WARMUP - 1);
	localparam logic [STEP_W-1:0] STEP_DEPTH = STEP_W'(TBL_DEPTH);

	// Lehmer constants
	localparam int VAL_W  = 31;
	localparam int MULT_W = 15;
	localparam int PROD_W = 32 + MULT_W;
	localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
	localparam logic [VAL_W-1:0]  LCG_MOD  = 31'h7FFF_FFFF;
	localparam logic [31:0] SLOT_DIV = 32'(64'd1 + 64'd2147483646 / 64'(TBL_DEPTH));

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] seed_value;
	} req_t;

	typedef struct packed {
		logic [30:0] raw_value;
		logic [23:0] fraction;
	} res_t;

	// value / SLOT_DIV: count the constant thresholds at or below the value
	function automatic logic [IDX_W-1:0] slot_of(input logic [VAL_W-1:0] v);
		logic [IDX_W:0] cnt;
		logic [31:0]    thr;
		cnt = '0;
		for (int k = 1; k < TBL_DEPTH; k++) begin
			thr = 32'(k) * SLOT_DIV;
			if ({1'b0, v} >= thr) begin
				cnt = cnt + (IDX_W + 1)'(1);
			end
		end
		return cnt[IDX_W-1:0];
	endfunction

endpackage

// ----- hdl/slrg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module slrg_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/shuffled_lehmer_random_generator_core.sv -----
// Top level of the shuffled Lehmer (minimal standard) generator with a shuffle table.
//
// Pulse start with busy low to request a number: req_type 0 draws the next value, req_type 1
// reseeds from seed_value (start is -seed_value when negative, else 1) and then draws. A draw
// while the last output is zero (never initialized, or left at zero by a degenerate seed) also
// reseeds. A plain draw is accepted into the fold state, so busy is high for one cycle, and
// the result beat shows on res with done high for exactly one cycle, registered as the fold
// state ends; a new request may be accepted in that same cycle. A reseed runs TBL_DEPTH+WARMUP
// seed steps and then the draw: each seed step is a multiply (at acceptance for the first, else
// in the multiply state) followed by a fold-and-reduce, and the draw itself issues its table
// read with its multiply and uses the data in its fold. There is no backpressure on
// results: capture res whenever done is high; res then holds until the next draw. raw_value is the
// 31-bit shuffled integer; fraction is raw_value >> 7, an unsigned 0.24 deviate below 1.0.
module shuffled_lehmer_random_generator_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  slrg_pkg::req_t req,
	output logic           done,
	output slrg_pkg::res_t res
);
	import slrg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_FOLD = 3'b100
	} state_t;

	state_t              state_q;
	logic [31:0]         seed_q;     // bit 31 is always zero; a fresh start value bypasses this register
	logic [VAL_W-1:0]    last_q;     // zero means never initialized, or zeroed by a degenerate seed
	logic [STEP_W-1:0]   step_q;     // warmup step, counts down to zero
	logic                init_q;     // running the warmup sequence
	logic [PROD_W-1:0]   prod_s1;
	logic                done_q;
	res_t                res_q;

	logic                accept;
	logic                need_init;
	logic [31:0]         seed_in;
	logic [31:0]         start_val;
	logic [31:0]         mul_opnd;
	logic                mul_en;
	logic [31:0]         fold_sum;
	logic [31:0]         fold_red;
	logic [VAL_W-1:0]    seed_nxt;
	logic [IDX_W-1:0]    slot;
	logic                step_in_tbl;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic                mem_re;
	logic [VAL_W-1:0]    mem_rdata;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start & ~busy;
	assign need_init = req.req_type | (last_q == '0);

	// magnitude of a negative seed, otherwise one; the most negative value gives 2^31
	assign seed_in   = req.seed_value;
	assign start_val = seed_in[31] ? (~seed_in + 32'd1) : 32'd1;

	// a fresh start value goes straight into the multiplier at acceptance
	assign mul_opnd = ((state_q == ST_IDLE) && need_init) ? start_val : seed_q;
	assign mul_en   = ((state_q == ST_IDLE) && accept) || (state_q == ST_MUL);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= PROD_W'(mul_opnd) * PROD_W'(LCG_MULT);
		end
	end

	// mod 2^31-1: 2^31 is congruent to 1, so add the high part onto the low part,
	// then one conditional subtract brings the sum below the modulus
	assign fold_sum = {1'b0, prod_s1[VAL_W-1:0]} + 32'(prod_s1[PROD_W-1:VAL_W]);
	assign fold_red = (fold_sum >= {1'b0, LCG_MOD}) ? (fold_sum - {1'b0, LCG_MOD}) : fold_sum;
	assign seed_nxt = fold_red[VAL_W-1:0];

	// table slot picked by the previous output
	assign slot        = slot_of(last_q);
	assign step_in_tbl = (step_q < STEP_DEPTH);

	// write: warmup fills its slot, a draw replaces the slot it just read
	assign mem_we    = (state_q == ST_FOLD) && (init_q ? step_in_tbl : 1'b1);
	assign mem_waddr = init_q ? step_q[IDX_W-1:0] : slot;
	// read: issued together with the multiply of the draw step
	assign mem_re    = ((state_q == ST_IDLE) && accept && !need_init) ||
	                   ((state_q == ST_MUL) && !init_q);

	slrg_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TBL_DEPTH)
	) u_tbl (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (seed_nxt),
		.re    (mem_re),
		.raddr (slot),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seed_q  <= '0;
			last_q  <= '0;
			step_q  <= '0;
			init_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						init_q <= need_init;
						if (need_init) begin
							step_q <= STEP_LAST;
						end
						state_q <= ST_FOLD;
					end
				end
				ST_MUL: begin
					state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					seed_q <= {1'b0, seed_nxt};
					if (init_q) begin
						if (step_q == '0) begin
							// slot zero holds the newest seed; it seeds the first index
							last_q  <= seed_nxt;
							init_q  <= 1'b0;
						end else begin
							step_q <= step_q - STEP_W'(1);
						end
						state_q <= ST_MUL;
					end else begin
						last_q  <= mem_rdata;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result beat register; no reset needed, qualified by done
	always_ff @(posedge clk) begin
		if ((state_q == ST_FOLD) && !init_q) begin
			res_q.raw_value <= mem_rdata;
			res_q.fraction  <= mem_rdata[VAL_W-1:7];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- hdl/slrg_checker.sv -----
// Port-level checks for the shuffled Lehmer generator, bound to the top level.
module slrg_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input slrg_pkg::res_t res
);
	import slrg_pkg::*;

	// the deviate is the integer scaled down
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.fraction == res.raw_value[30:7]))
		else $error("fraction does not match raw_value");

	// an accepted request makes the block busy in the cycle after
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");

	// finishing a request always delivers a beat
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	// no two result beats are back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result beats");

endmodule

bind shuffled_lehmer_random_generator_core slrg_checker u_slrg_checker (.*);
